[src/salb_pkg.sv]
// ----------------------------------------------------------------------------
// salb_pkg - shared types and constants of the suffix array / LCP builder
// Field widths, opcodes, status codes and the request/response structs that
// run between the command front end and the build engine.
// ----------------------------------------------------------------------------
`default_nettype none
package salb_pkg;

	localparam int ADDR_W = 10;   // one entry per text position
	localparam int POS_W  = 11;   // positions, ranks and lengths 0..1024
	localparam int SYM_W  = 7;
	localparam int LCP_W  = 10;
	localparam int KEY_DEPTH = 1025;  // bucket keys 0..1024

	localparam logic [POS_W-1:0] MAX_LEN    = 11'd1024;
	localparam logic [SYM_W-1:0] SYMBOL_MAX = 7'd127;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_BUILD  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BAD_SYM = 2'd2;
	localparam logic [1:0] ST_BAD_IDX = 2'd3;

	typedef struct packed {
		logic             go;
		logic [1:0]       kind;
		logic [SYM_W-1:0] sym;
		logic [POS_W-1:0] pos;   // append: slot, read: rank, build: length
	} salb_req_t;

	typedef struct packed {
		logic             done;
		logic [POS_W-1:0] start;
		logic [LCP_W-1:0] lcp;
	} salb_rsp_t;

endpackage
`default_nettype wire

[src/salb_engine.sv]
// ----------------------------------------------------------------------------
// salb_engine - memory sequencer for suffix array and LCP construction
// Holds the text, suffix order, ranks, old ranks, order list, buckets and
// LCP values in single-port-write, registered-read memories and steps the
// prefix-doubling radix passes and the Kasai scan one access at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module salb_engine (
	input  wire                  clk,
	input  wire                  arst_n,
	input  salb_pkg::salb_req_t  req,
	output salb_pkg::salb_rsp_t  rsp
);
	import salb_pkg::*;

	localparam logic [5:0] S_IDLE     = 6'd0;
	localparam logic [5:0] S_RDW      = 6'd1;
	localparam logic [5:0] S_INIT_RD  = 6'd2;
	localparam logic [5:0] S_INIT_WR  = 6'd3;
	localparam logic [5:0] S_CLR      = 6'd4;
	localparam logic [5:0] S_CNT_RD   = 6'd5;
	localparam logic [5:0] S_CNT_K    = 6'd6;
	localparam logic [5:0] S_CNT_WR   = 6'd7;
	localparam logic [5:0] S_SUM0     = 6'd8;
	localparam logic [5:0] S_SUM0W    = 6'd9;
	localparam logic [5:0] S_SUM_RD   = 6'd10;
	localparam logic [5:0] S_SUM_WR   = 6'd11;
	localparam logic [5:0] S_PL_RD    = 6'd12;
	localparam logic [5:0] S_PL_POS   = 6'd13;
	localparam logic [5:0] S_PL_KEY   = 6'd14;
	localparam logic [5:0] S_PL_WR    = 6'd15;
	localparam logic [5:0] S_ROUND    = 6'd16;
	localparam logic [5:0] S_TMPA     = 6'd17;
	localparam logic [5:0] S_TMPB_RD  = 6'd18;
	localparam logic [5:0] S_TMPB_WR  = 6'd19;
	localparam logic [5:0] S_COPY_RD  = 6'd20;
	localparam logic [5:0] S_COPY_WR  = 6'd21;
	localparam logic [5:0] S_RR_RD    = 6'd22;
	localparam logic [5:0] S_RR_A     = 6'd23;
	localparam logic [5:0] S_RR_OA    = 6'd24;
	localparam logic [5:0] S_RR_OK    = 6'd25;
	localparam logic [5:0] S_K_RD     = 6'd26;
	localparam logic [5:0] S_K_R      = 6'd27;
	localparam logic [5:0] S_K_J      = 6'd28;
	localparam logic [5:0] S_K_CMP    = 6'd29;
	localparam logic [5:0] S_K_S1     = 6'd30;
	localparam logic [5:0] S_K_S2     = 6'd31;
	localparam logic [5:0] S_FIN      = 6'd32;

	// memories
	logic [SYM_W-1:0] sym_mem  [0:MAX_LEN-1];
	logic [POS_W-1:0] sa_mem   [0:MAX_LEN-1];
	logic [POS_W-1:0] rank_mem [0:MAX_LEN-1];
	logic [POS_W-1:0] old_mem  [0:MAX_LEN-1];
	logic [POS_W-1:0] tmp_mem  [0:MAX_LEN-1];
	logic [POS_W-1:0] bkt_mem  [0:KEY_DEPTH-1];
	logic [LCP_W-1:0] lcp_mem  [0:MAX_LEN-1];

	logic              sym_we, sa_we, rank_we, old_we, tmp_we, bkt_we, lcp_we;
	logic [ADDR_W-1:0] sym_wa, sa_wa, rank_wa, old_wa, tmp_wa, lcp_wa;
	logic [ADDR_W-1:0] sym_ra, sa_ra, rank_ra, old_ra, tmp_ra, lcp_ra;
	logic [POS_W-1:0]  bkt_wa, bkt_ra;
	logic [SYM_W-1:0]  sym_wd, sym_rd;
	logic [POS_W-1:0]  sa_wd, rank_wd, old_wd, tmp_wd, bkt_wd;
	logic [POS_W-1:0]  sa_rd, rank_rd, old_rd, tmp_rd, bkt_rd;
	logic [LCP_W-1:0]  lcp_wd, lcp_rd;

	always_ff @(posedge clk) begin
		if (sym_we) sym_mem[sym_wa] <= sym_wd;
		sym_rd <= sym_mem[sym_ra];
	end
	always_ff @(posedge clk) begin
		if (sa_we) sa_mem[sa_wa] <= sa_wd;
		sa_rd <= sa_mem[sa_ra];
	end
	always_ff @(posedge clk) begin
		if (rank_we) rank_mem[rank_wa] <= rank_wd;
		rank_rd <= rank_mem[rank_ra];
	end
	always_ff @(posedge clk) begin
		if (old_we) old_mem[old_wa] <= old_wd;
		old_rd <= old_mem[old_ra];
	end
	always_ff @(posedge clk) begin
		if (tmp_we) tmp_mem[tmp_wa] <= tmp_wd;
		tmp_rd <= tmp_mem[tmp_ra];
	end
	always_ff @(posedge clk) begin
		if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
		bkt_rd <= bkt_mem[bkt_ra];
	end
	always_ff @(posedge clk) begin
		if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
		lcp_rd <= lcp_mem[lcp_ra];
	end

	// sequencer registers
	logic [5:0]       st_q;
	logic [POS_W-1:0] i_q, w_q, n_q, m_q, cnt_q, acc_q, pos_q, key_q;
	logic [POS_W-1:0] a_q, oa_q, pb_q, pbk_q, h_q, r_q, j_q;
	logic [12:0]      k_q;
	logic [SYM_W-1:0] s1_q;
	logic             round_q, rd_one_q;

	logic [POS_W-1:0] im1, tmp_m1, sa_m1, bkt_m1, rank_m2, a_m1, r_m1, req_m1;
	logic [POS_W-1:0] key_c, sum_c, oak_c, cnt_c, nk_c, sa_k;
	logic [13:0]      ak;
	logic [13:0]      ak_m1;
	logic [11:0]      ih, jh, ih_m1, jh_m1;
	logic             ak_in, same_c, pos_ok, c_ok, kas_end_cmp, kas_end_s1;

	assign im1     = i_q - 11'd1;
	assign tmp_m1  = tmp_rd - 11'd1;
	assign sa_m1   = sa_rd - 11'd1;
	assign bkt_m1  = bkt_rd - 11'd1;
	assign rank_m2 = rank_rd - 11'd2;
	assign a_m1    = a_q - 11'd1;
	assign r_m1    = r_q - 11'd1;
	assign req_m1  = req.pos - 11'd1;
	assign key_c   = (rank_rd > m_q) ? m_q : rank_rd;
	assign sum_c   = acc_q + bkt_rd;
	assign ak      = {3'b000, a_q} + {1'b0, k_q};
	assign ak_m1   = ak - 14'd1;
	assign ak_in   = ak <= {3'b000, n_q};
	assign oak_c   = ak_in ? old_rd : '0;
	assign same_c  = (i_q != 11'd1) && (oa_q == pb_q) && (oak_c == pbk_q);
	assign cnt_c   = same_c ? cnt_q : cnt_q + 11'd1;
	assign nk_c    = n_q - k_q[POS_W-1:0] + 11'd1;
	assign sa_k    = sa_rd - k_q[POS_W-1:0];
	assign pos_ok  = (pos_q != '0) && (pos_q <= n_q);
	assign c_ok    = (bkt_rd != '0) && (bkt_rd <= n_q);
	assign ih      = {1'b0, i_q} + {1'b0, h_q};
	assign jh      = {1'b0, j_q} + {1'b0, h_q};
	assign ih_m1   = ih - 12'd1;
	assign jh_m1   = jh - 12'd1;
	assign kas_end_cmp = (h_q >= n_q) || (ih > {1'b0, n_q});
	assign kas_end_s1  = jh > {1'b0, n_q};

	// memory ports
	always_comb begin
		sym_we = 1'b0; sym_wa = req.pos[ADDR_W-1:0]; sym_wd = req.sym; sym_ra = im1[ADDR_W-1:0];
		sa_we = 1'b0; sa_wa = bkt_m1[ADDR_W-1:0]; sa_wd = pos_q; sa_ra = im1[ADDR_W-1:0];
		rank_we = 1'b0; rank_wa = im1[ADDR_W-1:0]; rank_wd = {4'b0000, sym_rd};
		rank_ra = im1[ADDR_W-1:0];
		old_we = 1'b0; old_wa = im1[ADDR_W-1:0]; old_wd = rank_rd; old_ra = sa_m1[ADDR_W-1:0];
		tmp_we = 1'b0; tmp_wa = im1[ADDR_W-1:0]; tmp_wd = i_q; tmp_ra = im1[ADDR_W-1:0];
		bkt_we = 1'b0; bkt_wa = i_q; bkt_wd = '0; bkt_ra = key_c;
		lcp_we = 1'b0; lcp_wa = r_m1[ADDR_W-1:0]; lcp_wd = h_q[LCP_W-1:0];
		lcp_ra = req_m1[ADDR_W-1:0];
		unique case (st_q)
			S_IDLE: begin
				sym_we = req.go && (req.kind == OP_APPEND);
				sa_ra  = req_m1[ADDR_W-1:0];
			end
			S_INIT_WR: begin
				rank_we = 1'b1;
				tmp_we  = 1'b1;
			end
			S_CLR: begin
				bkt_we = 1'b1;
			end
			S_CNT_WR: begin
				bkt_we = 1'b1;
				bkt_wa = key_q;
				bkt_wd = bkt_rd + 11'd1;
			end
			S_SUM0: begin
				bkt_ra = '0;
			end
			S_SUM_RD: begin
				bkt_ra = i_q;
			end
			S_SUM_WR: begin
				bkt_we = 1'b1;
				bkt_wd = sum_c;
			end
			S_PL_POS: begin
				rank_ra = tmp_m1[ADDR_W-1:0];
			end
			S_PL_WR: begin
				sa_we  = pos_ok && c_ok;
				bkt_we = pos_ok && c_ok;
				bkt_wa = key_q;
				bkt_wd = bkt_m1;
			end
			S_TMPA: begin
				tmp_we = i_q <= n_q;
				tmp_wa = w_q[ADDR_W-1:0];
			end
			S_TMPB_WR: begin
				tmp_we = {2'b00, sa_rd} > k_q;
				tmp_wa = w_q[ADDR_W-1:0];
				tmp_wd = sa_k;
			end
			S_COPY_WR: begin
				old_we = 1'b1;
			end
			S_RR_OA: begin
				old_ra = ak_m1[ADDR_W-1:0];
			end
			S_RR_OK: begin
				rank_we = 1'b1;
				rank_wa = a_m1[ADDR_W-1:0];
				rank_wd = cnt_c;
			end
			S_K_R: begin
				sa_ra  = rank_m2[ADDR_W-1:0];
				lcp_we = rank_rd == 11'd1;
				lcp_wa = '0;
				lcp_wd = '0;
			end
			S_K_CMP: begin
				lcp_we = kas_end_cmp;
				sym_ra = ih_m1[ADDR_W-1:0];
			end
			S_K_S1: begin
				lcp_we = kas_end_s1;
				sym_ra = jh_m1[ADDR_W-1:0];
			end
			S_K_S2: begin
				lcp_we = sym_rd != s1_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			round_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (req.go && req.kind == OP_READ) begin
						rd_one_q <= req.pos == 11'd1;
						st_q     <= S_RDW;
					end else if (req.go && req.kind == OP_BUILD) begin
						n_q     <= req.pos;
						i_q     <= 11'd1;
						m_q     <= {4'b0000, SYMBOL_MAX};
						round_q <= 1'b0;
						st_q    <= S_INIT_RD;
					end
				end
				S_RDW: st_q <= S_IDLE;
				S_INIT_RD: begin
					if (i_q > n_q) begin
						i_q  <= '0;
						st_q <= S_CLR;
					end else begin
						st_q <= S_INIT_WR;
					end
				end
				S_INIT_WR: begin
					i_q  <= i_q + 11'd1;
					st_q <= S_INIT_RD;
				end
				S_CLR: begin
					if (i_q == m_q) begin
						i_q  <= 11'd1;
						st_q <= S_CNT_RD;
					end else begin
						i_q <= i_q + 11'd1;
					end
				end
				S_CNT_RD: st_q <= (i_q > n_q) ? S_SUM0 : S_CNT_K;
				S_CNT_K: begin
					key_q <= key_c;
					st_q  <= S_CNT_WR;
				end
				S_CNT_WR: begin
					i_q  <= i_q + 11'd1;
					st_q <= S_CNT_RD;
				end
				S_SUM0: st_q <= S_SUM0W;
				S_SUM0W: begin
					acc_q <= bkt_rd;
					i_q   <= 11'd1;
					st_q  <= S_SUM_RD;
				end
				S_SUM_RD: begin
					if (i_q > m_q) begin
						i_q  <= n_q;
						st_q <= S_PL_RD;
					end else begin
						st_q <= S_SUM_WR;
					end
				end
				S_SUM_WR: begin
					acc_q <= sum_c;
					i_q   <= i_q + 11'd1;
					st_q  <= S_SUM_RD;
				end
				S_PL_RD: begin
					if (i_q == '0) begin
						i_q <= 11'd1;
						if (round_q) begin
							st_q <= S_COPY_RD;
						end else begin
							round_q <= 1'b1;
							k_q     <= 13'd1;
							cnt_q   <= '0;
							st_q    <= S_ROUND;
						end
					end else begin
						st_q <= S_PL_POS;
					end
				end
				S_PL_POS: begin
					pos_q <= tmp_rd;
					st_q  <= S_PL_KEY;
				end
				S_PL_KEY: begin
					key_q <= key_c;
					st_q  <= S_PL_WR;
				end
				S_PL_WR: begin
					i_q  <= im1;
					st_q <= S_PL_RD;
				end
				S_ROUND: begin
					if (cnt_q < n_q && k_q <= {1'b0, n_q, 1'b0}) begin
						w_q  <= '0;
						i_q  <= ({2'b00, n_q} > k_q) ? nk_c : 11'd1;
						st_q <= S_TMPA;
					end else begin
						i_q  <= 11'd1;
						h_q  <= '0;
						st_q <= S_K_RD;
					end
				end
				S_TMPA: begin
					if (i_q > n_q) begin
						i_q  <= 11'd1;
						st_q <= S_TMPB_RD;
					end else begin
						w_q <= w_q + 11'd1;
						i_q <= i_q + 11'd1;
					end
				end
				S_TMPB_RD: begin
					if (i_q > n_q) begin
						i_q  <= '0;
						st_q <= S_CLR;
					end else begin
						st_q <= S_TMPB_WR;
					end
				end
				S_TMPB_WR: begin
					if ({2'b00, sa_rd} > k_q) w_q <= w_q + 11'd1;
					i_q  <= i_q + 11'd1;
					st_q <= S_TMPB_RD;
				end
				S_COPY_RD: begin
					if (i_q > n_q) begin
						i_q   <= 11'd1;
						cnt_q <= '0;
						st_q  <= S_RR_RD;
					end else begin
						st_q <= S_COPY_WR;
					end
				end
				S_COPY_WR: begin
					i_q  <= i_q + 11'd1;
					st_q <= S_COPY_RD;
				end
				S_RR_RD: begin
					if (i_q > n_q) begin
						m_q  <= cnt_q;
						k_q  <= {k_q[11:0], 1'b0};
						st_q <= S_ROUND;
					end else begin
						st_q <= S_RR_A;
					end
				end
				S_RR_A: begin
					a_q  <= sa_rd;
					st_q <= S_RR_OA;
				end
				S_RR_OA: begin
					oa_q <= old_rd;
					st_q <= S_RR_OK;
				end
				S_RR_OK: begin
					cnt_q <= cnt_c;
					pb_q  <= oa_q;
					pbk_q <= oak_c;
					i_q   <= i_q + 11'd1;
					st_q  <= S_RR_RD;
				end
				S_K_RD: st_q <= (i_q > n_q) ? S_FIN : S_K_R;
				S_K_R: begin
					r_q <= rank_rd;
					if (rank_rd == '0 || rank_rd > n_q) begin
						i_q  <= i_q + 11'd1;
						st_q <= S_K_RD;
					end else if (rank_rd == 11'd1) begin
						h_q  <= '0;
						i_q  <= i_q + 11'd1;
						st_q <= S_K_RD;
					end else begin
						if (h_q != '0) h_q <= h_q - 11'd1;
						st_q <= S_K_J;
					end
				end
				S_K_J: begin
					j_q  <= sa_rd;
					st_q <= S_K_CMP;
				end
				S_K_CMP: begin
					if (kas_end_cmp) begin
						i_q  <= i_q + 11'd1;
						st_q <= S_K_RD;
					end else begin
						st_q <= S_K_S1;
					end
				end
				S_K_S1: begin
					s1_q <= sym_rd;
					if (kas_end_s1) begin
						i_q  <= i_q + 11'd1;
						st_q <= S_K_RD;
					end else begin
						st_q <= S_K_S2;
					end
				end
				S_K_S2: begin
					if (sym_rd == s1_q) begin
						h_q  <= h_q + 11'd1;
						st_q <= S_K_CMP;
					end else begin
						i_q  <= i_q + 11'd1;
						st_q <= S_K_RD;
					end
				end
				S_FIN: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done  = (st_q == S_RDW) || (st_q == S_FIN);
	assign rsp.start = (st_q == S_RDW) ? sa_rd : '0;
	assign rsp.lcp   = (st_q == S_RDW && !rd_one_q) ? lcp_rd : '0;

endmodule
`default_nettype wire

[src/suffix_array_lcp_builder_unit.sv]
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_unit - text store with suffix array / LCP build
// Command front end with one result beat per command beat; the build and
// the lookups run in a memory sequencer.
// ----------------------------------------------------------------------------
// Feed commands as beats: clear, append a symbol (1..127, up to 1024 of
// them), build, and read a rank. Every command yields exactly one result
// beat carrying a status, the suffix start and LCP for a read, and the text
// length after the command. Clear, append and any rejected read are
// answered by the front end; a good read makes one registered memory
// read. Build blocks the input while the sequencer walks the memories one
// access at a time: it seeds the ranks, then runs radix passes over key
// range m (127 at first, then the rank count), and per doubling round a
// list rebuild, rank copy and re-rank, with about log2(n) rounds, followed
// by a Kasai scan. Each memory has one write and one read port. No memory
// is cleared after reset, so the unit takes commands straight away.
`default_nettype none
module suffix_array_lcp_builder_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // symbol[6:0], rank_index[17:7], zero
	input  wire  [1:0]  s_axis_tuser,   // opcode[1:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // suffix_start[10:0], common_prefix[20:11],
	                                    // text_length[31:21]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);
	import salb_pkg::*;

	salb_req_t req;
	salb_rsp_t rsp;

	logic [1:0]       op;
	logic [SYM_W-1:0] sym;
	logic [POS_W-1:0] idx;
	logic             s_accept, m_accept;
	logic             sym_bad, store_full, read_ok;
	logic             post_now;
	logic [1:0]       beat_status;
	logic [POS_W-1:0] beat_len;

	logic [POS_W-1:0] len_q;
	logic             built_q, busy_q, busy_build_q, out_valid_q;
	logic [1:0]       out_status_q;
	logic [POS_W-1:0] out_start_q, out_len_q;
	logic [LCP_W-1:0] out_lcp_q;

	assign op  = s_axis_tuser;
	assign sym = s_axis_tdata[6:0];
	assign idx = s_axis_tdata[17:7];

	// take a beat only when the sequencer is free and the output slot frees up
	assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign m_accept      = m_axis_tvalid && m_axis_tready;

	assign sym_bad    = (sym == '0) || (sym > SYMBOL_MAX);
	assign store_full = len_q >= MAX_LEN;
	assign read_ok    = built_q && (idx != '0) && (idx <= len_q);

	// hand appends, builds and good reads to the sequencer
	always_comb begin
		req.go   = 1'b0;
		req.kind = op;
		req.sym  = sym;
		req.pos  = len_q;
		unique case (op)
			OP_APPEND: req.go = s_accept && !sym_bad && !store_full;
			OP_BUILD:  req.go = s_accept;
			OP_READ: begin
				req.go  = s_accept && read_ok;
				req.pos = idx;
			end
			default: req.go = 1'b0;
		endcase
	end

	salb_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// immediate answer for the beat on the input; builds and good reads post later
	always_comb begin
		beat_status = ST_OK;
		beat_len    = len_q;
		post_now    = 1'b1;
		unique case (op)
			OP_CLEAR: beat_len = '0;
			OP_APPEND: begin
				if (sym_bad) begin
					beat_status = ST_BAD_SYM;
				end else if (store_full) begin
					beat_status = ST_FULL;
				end else begin
					beat_len = len_q + 11'd1;
				end
			end
			OP_BUILD: post_now = 1'b0;
			OP_READ: begin
				if (read_ok) begin
					post_now = 1'b0;
				end else begin
					beat_status = ST_BAD_IDX;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			built_q      <= 1'b0;
			busy_q       <= 1'b0;
			busy_build_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// load the slot on a new answer, else drop it once taken
			if ((s_accept && post_now) || rsp.done) begin
				out_valid_q <= 1'b1;
			end else if (m_accept) begin
				out_valid_q <= 1'b0;
			end
			if (s_accept) begin
				unique case (op)
					OP_CLEAR: begin
						len_q   <= '0;
						built_q <= 1'b0;
					end
					OP_APPEND: begin
						if (!sym_bad && !store_full) begin
							len_q   <= len_q + 11'd1;
							built_q <= 1'b0;
						end
					end
					OP_BUILD: begin
						busy_q       <= 1'b1;
						busy_build_q <= 1'b1;
					end
					OP_READ: begin
						if (read_ok) begin
							busy_q       <= 1'b1;
							busy_build_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end else if (rsp.done) begin
				// sequencer finished: drop busy
				busy_q <= 1'b0;
				if (busy_build_q) built_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			out_start_q  <= '0;
			out_lcp_q    <= '0;
			out_status_q <= beat_status;
			out_len_q    <= beat_len;
		end else if (rsp.done) begin
			out_start_q <= rsp.start;
			out_lcp_q   <= rsp.lcp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_lcp_q, out_start_q};
	assign m_axis_tuser  = out_status_q;

	// the sequencer only answers a command it was given
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> busy_q)
		else $error("sequencer done without a pending command");

	// the output slot is empty when the sequencer answers
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !out_valid_q)
		else $error("result beat overwritten");

	// built flag only rises at the end of a build
	a_built_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> $past(rsp.done && busy_build_q))
		else $error("built flag set outside a build");

	// text never exceeds the store
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= MAX_LEN)
		else $error("text length beyond store");

endmodule
`default_nettype wire

[test/tb_suffix_array_lcp_builder_unit.sv]
// ----------------------------------------------------------------------------
// tb_suffix_array_lcp_builder_unit - self-checking bench for the SA/LCP unit
// Drives clear, append, build and read command beats and predicts each result
// beat from a behavioral text store that sorts suffixes by direct comparison.
// Both stream sides idle in phases. Results are checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_suffix_array_lcp_builder_unit;
	import salb_pkg::*;

	typedef struct {
		logic [1:0]       st;
		logic [POS_W-1:0] start;
		logic [LCP_W-1:0] lcp;
		logic [POS_W-1:0] len;
	} result_t;

	typedef struct {
		logic [1:0]       op;
		logic [SYM_W-1:0] sym;
		logic [POS_W-1:0] idx;
		bit               typed;   // expectation typed in below
		result_t          res;
	} cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [31:0] m_axis_tdata;
	wire  [1:0]  m_axis_tuser;

	always #2 clk = ~clk;

	suffix_array_lcp_builder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// behavioral text store
	int      text_sym [1:1024];
	int      rank_pos [1:1024];   // suffix start per rank
	int      rank_lcp [1:1024];
	int      text_len = 0;
	bit      arrays_ok = 0;
	result_t pending_results [$];
	int      fail_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	function automatic int char_at(int p);
		return (p >= 1 && p <= text_len) ? text_sym[p] : 0;
	endfunction

	// suffix a sorts before suffix b; the end marker is lowest
	function automatic bit suffix_less(int a, int b);
		int t;
		t = 0;
		while (char_at(a + t) == char_at(b + t)) t++;
		return char_at(a + t) < char_at(b + t);
	endfunction

	function automatic void sort_suffixes();
		int i, j, p, h;
		for (i = 1; i <= text_len; i++) begin
			p = i;
			j = i - 1;
			while (j >= 1 && suffix_less(p, rank_pos[j])) begin
				rank_pos[j + 1] = rank_pos[j];
				j--;
			end
			rank_pos[j + 1] = p;
		end
		for (i = 2; i <= text_len; i++) begin
			h = 0;
			while (char_at(rank_pos[i] + h) != 0 &&
			       char_at(rank_pos[i] + h) == char_at(rank_pos[i - 1] + h))
				h++;
			rank_lcp[i] = h;
		end
		arrays_ok = 1;
	endfunction

	function automatic result_t apply_command(logic [1:0] op, logic [SYM_W-1:0] sym,
	                                          logic [POS_W-1:0] idx);
		result_t r;
		r.st = ST_OK;
		r.start = '0;
		r.lcp = '0;
		case (op)
			OP_CLEAR: begin
				text_len = 0;
				arrays_ok = 0;
			end
			OP_APPEND: begin
				if (sym == 0)
					r.st = ST_BAD_SYM;
				else if (text_len >= MAX_LEN)
					r.st = ST_FULL;
				else begin
					text_len++;
					text_sym[text_len] = sym;
					arrays_ok = 0;
				end
			end
			OP_BUILD: sort_suffixes();
			default: begin
				if (!arrays_ok || idx < 1 || idx > text_len)
					r.st = ST_BAD_IDX;
				else begin
					r.start = rank_pos[idx];
					r.lcp = (idx == 1) ? '0 : rank_lcp[idx];
				end
			end
		endcase
		r.len = text_len;
		return r;
	endfunction

	// Hold the beat until accepted, then record what it must produce.
	task automatic send_beat(logic [1:0] op, logic [SYM_W-1:0] sym, logic [POS_W-1:0] idx,
	                         bit typed = 0, result_t typed_res = '{default: '0});
		result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, idx, sym};
		do @(posedge clk); while (!s_axis_tready);
		r = apply_command(op, sym, idx);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	// result side: random stall, compare against the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat %h/%h", $realtime, m_axis_tuser,
				         m_axis_tdata);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tuser !== e.st || m_axis_tdata[10:0] !== e.start ||
				    m_axis_tdata[20:11] !== e.lcp || m_axis_tdata[31:21] !== e.len) begin
					$display("%0t: mismatch exp st=%0d start=%0d lcp=%0d len=%0d got st=%0d start=%0d lcp=%0d len=%0d",
					         $realtime, e.st, e.start, e.lcp, e.len, m_axis_tuser,
					         m_axis_tdata[10:0], m_axis_tdata[20:11], m_axis_tdata[31:21]);
					fail_count++;
				end
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic set_idling(int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	cmd_row_t directed [] = '{
		'{OP_READ,   7'd0,   11'd1,    1, '{ST_BAD_IDX, 11'd0, 10'd0, 11'd0}},  // not built
		'{OP_APPEND, 7'd0,   11'd0,    1, '{ST_BAD_SYM, 11'd0, 10'd0, 11'd0}},
		'{OP_BUILD,  7'd0,   11'd0,    1, '{ST_OK,      11'd0, 10'd0, 11'd0}},  // empty text
		'{OP_READ,   7'd0,   11'd1,    1, '{ST_BAD_IDX, 11'd0, 10'd0, 11'd0}},
		'{OP_APPEND, 7'd127, 11'd0,    1, '{ST_OK,      11'd0, 10'd0, 11'd1}},
		'{OP_READ,   7'd0,   11'd1,    1, '{ST_BAD_IDX, 11'd0, 10'd0, 11'd1}},  // stale
		'{OP_BUILD,  7'd0,   11'd0,    1, '{ST_OK,      11'd0, 10'd0, 11'd1}},
		'{OP_READ,   7'd0,   11'd1,    1, '{ST_OK,      11'd1, 10'd0, 11'd1}},
		'{OP_APPEND, 7'd1,   11'd0,    0, '{default: '0}},
		'{OP_APPEND, 7'd127, 11'd0,    0, '{default: '0}},
		'{OP_APPEND, 7'd1,   11'd0,    0, '{default: '0}},
		'{OP_APPEND, 7'd85,  11'd0,    0, '{default: '0}},
		'{OP_APPEND, 7'd42,  11'd0,    0, '{default: '0}},
		'{OP_BUILD,  7'd0,   11'd0,    0, '{default: '0}},
		'{OP_READ,   7'd0,   11'd1,    0, '{default: '0}},
		'{OP_READ,   7'd0,   11'd2,    0, '{default: '0}},
		'{OP_READ,   7'd0,   11'd3,    0, '{default: '0}},
		'{OP_READ,   7'd0,   11'd4,    0, '{default: '0}},
		'{OP_READ,   7'd0,   11'd6,    0, '{default: '0}},
		'{OP_READ,   7'd0,   11'd0,    1, '{ST_BAD_IDX, 11'd0, 10'd0, 11'd6}},
		'{OP_READ,   7'd0,   11'd7,    1, '{ST_BAD_IDX, 11'd0, 10'd0, 11'd6}},
		'{OP_READ,   7'd127, 11'd2047, 1, '{ST_BAD_IDX, 11'd0, 10'd0, 11'd6}},
		'{OP_CLEAR,  7'd127, 11'd2047, 1, '{ST_OK,      11'd0, 10'd0, 11'd0}},
		'{OP_READ,   7'd0,   11'd1,    1, '{ST_BAD_IDX, 11'd0, 10'd0, 11'd0}}
	};

	initial begin
		int i, k, n, alpha, phase;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_beat(directed[i].op, directed[i].sym, directed[i].idx,
			          directed[i].typed, directed[i].res);

		// fill the store to the limit on a two-letter alphabet
		set_idling(3);
		for (i = 0; i < 1024; i++) begin
			if (i % 256 == 0) set_idling(i / 256);
			send_beat(OP_APPEND, 7'($urandom_range(2, 1)), 11'($urandom));
		end
		send_beat(OP_APPEND, 7'd5, '0, 1, '{ST_FULL, 11'd0, 10'd0, 11'd1024});
		send_beat(OP_APPEND, 7'd0, '0, 1, '{ST_BAD_SYM, 11'd0, 10'd0, 11'd1024});
		send_beat(OP_BUILD, '0, '0);
		send_beat(OP_READ, '0, 11'd1024);
		send_beat(OP_READ, '0, 11'd1025, 1, '{ST_BAD_IDX, 11'd0, 10'd0, 11'd1024});
		for (i = 0; i < 30; i++)
			send_beat(OP_READ, '0, 11'($urandom_range(1024, 1)));

		// random texts: well-formed load/build/read runs, a little noise
		for (phase = 0; phase < 24; phase++) begin
			set_idling(phase);
			send_beat(OP_CLEAR, 7'($urandom), 11'($urandom));
			n = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(20, 1);
			case ($urandom_range(3))
				0: alpha = 1;
				1: alpha = 2;
				2: alpha = 4;
				default: alpha = 127;
			endcase
			if (alpha == 1 && n > 40) n = 40;
			for (i = 0; i < n; i++) begin
				if ($urandom_range(19) == 0)
					send_beat(2'($urandom), 7'($urandom), 11'($urandom));
				else
					send_beat(OP_APPEND, 7'($urandom_range(alpha, 1)), 11'($urandom));
			end
			send_beat(OP_BUILD, 7'($urandom), 11'($urandom));
			for (k = 0; k < 12; k++)
				send_beat(OP_READ, 7'($urandom),
				          ($urandom_range(7) == 0) ? 11'($urandom)
				                                   : 11'($urandom_range(text_len + 1)));
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hang guard: the full-store build dominates the run time
	initial begin
		#16000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
src/salb_pkg.sv
src/salb_engine.sv
src/suffix_array_lcp_builder_unit.sv
test/tb_suffix_array_lcp_builder_unit.sv
